// ===== design/mmh_pkg.sv =====
package mmh_pkg;

    // MurmurHash2 mixing constants
    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    // How the back end folds one word into the running hash
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,   // last item with no bytes: avalanche only
        OP_TAIL = 2'd1,   // last item with one to three bytes
        OP_FULL = 2'd2    // full four-byte word
    } mix_op_t;

    // Classified item as it travels from front to back
    typedef struct packed {
        logic [31:0] word;       // data word, tail bytes already masked
        logic [31:0] init_hash;  // seed XOR message length
        mix_op_t     op;
        logic        first;
        logic        last;
    } item_t;

endpackage

// ===== design/mmh_front.sv =====
module mmh_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [31:0]     cfg_wdata,
    input  logic [31:0]     s_data_word,
    input  logic [2:0]      s_byte_count,
    input  logic            s_is_first,
    input  logic            s_is_last,
    input  logic [31:0]     s_message_length,
    output mmh_pkg::item_t  item
);

    logic [31:0] seed_reg;

    // Hold the seed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_we) begin
            seed_reg <= cfg_wdata;
        end
    end

    // Classify the item and mask tail bytes
    always_comb begin
        item.init_hash = seed_reg ^ s_message_length;
        item.first     = s_is_first;
        item.last      = s_is_last;
        item.word      = s_data_word;
        priority if (!s_is_last || s_byte_count[2]) begin
            item.op = mmh_pkg::OP_FULL;
        end else if (s_byte_count[1:0] == 2'd0) begin
            item.op   = mmh_pkg::OP_NONE;
            item.word = '0;
        end else begin
            item.op = mmh_pkg::OP_TAIL;
            unique case (s_byte_count[1:0])
                2'd1:    item.word = {24'd0, s_data_word[7:0]};
                2'd2:    item.word = {16'd0, s_data_word[15:0]};
                default: item.word = {8'd0, s_data_word[23:0]};
            endcase
        end
    end

endmodule

// ===== design/mmh_queue.sv =====
module mmh_queue #(
    parameter int DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mmh_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output mmh_pkg::item_t  head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mmh_pkg::item_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];

    // Track fill level
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("queue overflow");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !head_valid))
        else $error("queue underflow");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== design/mmh_back.sv =====
module mmh_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  mmh_pkg::item_t  q_item,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [31:0]     m_hash_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_K1,
        S_K2,
        S_HM,
        S_FIN
    } state_t;

    state_t          state_reg;
    logic [31:0]     h_reg;
    logic [31:0]     k_reg;
    mmh_pkg::mix_op_t op_reg;
    logic            last_reg;
    logic            out_valid_reg;
    logic [31:0]     out_hash_reg;

    logic [31:0] base_hash;
    logic [31:0] mul_a;
    logic [31:0] prod;
    logic        out_free;

    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign base_hash    = q_item.first ? q_item.init_hash : h_reg;
    assign out_free     = !out_valid_reg || m_ready;
    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_hash_reg;

    // Select the operand of the shared multiplier
    always_comb begin
        unique case (state_reg)
            S_K1:    mul_a = k_reg;
            S_K2:    mul_a = k_reg ^ (k_reg >> mmh_pkg::MIX_SHIFT);
            S_FIN:   mul_a = h_reg ^ (h_reg >> mmh_pkg::FIN_SHIFT_A);
            default: mul_a = h_reg;
        endcase
    end

    // Keep only the low 32 bits of the product
    assign prod = mul_a * mmh_pkg::MIX_MUL;

    // Sequence the mix steps and hold the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            h_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // Raise the result on the finish step, drop it once transferred
            if (state_reg == S_FIN && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        k_reg    <= q_item.word;
                        op_reg   <= q_item.op;
                        last_reg <= q_item.last;
                        unique case (q_item.op)
                            mmh_pkg::OP_FULL: begin
                                h_reg     <= base_hash;
                                state_reg <= S_K1;
                            end
                            mmh_pkg::OP_TAIL: begin
                                h_reg     <= base_hash ^ q_item.word;
                                state_reg <= S_HM;
                            end
                            mmh_pkg::OP_NONE: begin
                                h_reg     <= base_hash;
                                state_reg <= q_item.last ? S_FIN : S_IDLE;
                            end
                            default: begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_K1: begin
                    k_reg     <= prod;
                    state_reg <= S_K2;
                end
                S_K2: begin
                    k_reg     <= prod;
                    state_reg <= S_HM;
                end
                S_HM: begin
                    h_reg     <= (op_reg == mmh_pkg::OP_FULL) ? (prod ^ k_reg) : prod;
                    state_reg <= last_reg ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    if (out_free) begin
                        out_hash_reg <= prod ^ (prod >> mmh_pkg::FIN_SHIFT_B);
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside finish step");

    a_fin_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && out_valid_reg && !m_ready) |=> state_reg == S_FIN)
        else $error("finish step left while output stalled");

    a_hash_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && !q_valid) |=> $stable(h_reg))
        else $error("running hash changed while idle");

endmodule

// ===== design/murmur2_hash_endian_neutral_core.sv =====
// 32-bit endian-neutral MurmurHash2 over a stream of little-endian words.
//
// Input channel (s_*): one message word per transfer. s_is_first starts a
// new hash from seed XOR s_message_length; s_is_last finishes it, and then
// s_byte_count (0..4) gives the valid bytes of that word. Result channel
// (m_*): one m_hash_value transfer per message, after its last word.
// cfg_we/cfg_wdata load the seed; write it only while the core is idle.
//
// A single 32x32 multiplier is shared by all mix steps, so the back end
// takes a full word through a pop and three multiplies, a tail of 1..3
// bytes through a pop and one multiply, and the final avalanche through
// one more step; a result reaches m_valid from the output register, after
// these steps and any queue wait; the back end pops a word only when idle.
// A small queue (QUEUE_DEPTH entries) lets the input side keep taking
// words while the back end mixes; s_ready drops only when it is full.
//
// Reset clears the seed and the running hash to zero and empties the
// queue. When the receiver stalls, the result holds in the output register
// and the back end waits when it reaches its finish step; the queue fills.
module murmur2_hash_endian_neutral_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_is_first,
    input  logic        s_is_last,
    input  logic [31:0] s_message_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);

    mmh_pkg::item_t front_item;
    mmh_pkg::item_t head_item;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    assign s_ready = !q_full;

    mmh_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_data_word      (s_data_word),
        .s_byte_count     (s_byte_count),
        .s_is_first       (s_is_first),
        .s_is_last        (s_is_last),
        .s_message_length (s_message_length),
        .item             (front_item)
    );

    mmh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid && s_ready),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    mmh_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule

// ===== test/hash_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the hash core, predicts every finished hash
// and compares it with what the core returns.
module hash_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_is_first,
    input  logic        s_is_last,
    input  logic [31:0] s_message_length,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_hash_value,
    output int          fail_count,
    output int          hashes_pending
);

    logic [31:0] seed_q;
    logic [31:0] running_q;
    logic [31:0] expected_hashes[$];

    // Scramble one full message word before it is folded in
    function automatic logic [31:0] scramble(input logic [31:0] k);
        logic [31:0] r;
        r = k * mmh_pkg::MIX_MUL;
        r = r ^ (r >> mmh_pkg::MIX_SHIFT);
        return r * mmh_pkg::MIX_MUL;
    endfunction

    // Final avalanche applied once the last word is in
    function automatic logic [31:0] finish_hash(input logic [31:0] h);
        logic [31:0] r;
        r = h ^ (h >> mmh_pkg::FIN_SHIFT_A);
        r = r * mmh_pkg::MIX_MUL;
        return r ^ (r >> mmh_pkg::FIN_SHIFT_B);
    endfunction

    // Non-last words are always full; counts above four saturate
    function automatic mmh_pkg::mix_op_t classify(input logic [2:0] count, input logic last);
        if (!last || count >= 3'd4)
            return mmh_pkg::OP_FULL;
        else if (count != 3'd0)
            return mmh_pkg::OP_TAIL;
        return mmh_pkg::OP_NONE;
    endfunction

    always @(posedge aclk) begin : predict
        logic [31:0] h;
        logic [31:0] tail_mask;
        logic [31:0] want;

        if (!aresetn) begin
            seed_q    = '0;
            running_q = '0;
            expected_hashes.delete();
        end else begin
            // Fold an accepted word into the running hash
            if (s_valid && s_ready) begin
                if (s_is_first)
                    running_q = seed_q ^ s_message_length;
                h = running_q;
                case (classify(s_byte_count, s_is_last))
                    mmh_pkg::OP_FULL: begin
                        h = (h * mmh_pkg::MIX_MUL) ^ scramble(s_data_word);
                    end
                    mmh_pkg::OP_TAIL: begin
                        tail_mask = 32'hFFFF_FFFF >> (8 * (4 - s_byte_count));
                        h = (h ^ (s_data_word & tail_mask)) * mmh_pkg::MIX_MUL;
                    end
                    default: begin
                    end
                endcase
                running_q = h;
                if (s_is_last)
                    expected_hashes.push_back(finish_hash(h));
            end

            // Compare a returned hash with the oldest one outstanding
            if (m_valid && m_ready) begin
                if (expected_hashes.size() == 0) begin
                    $error("hash_value transfer with no message pending: actual %h",
                           m_hash_value);
                    fail_count++;
                end else begin
                    want = expected_hashes.pop_front();
                    if (m_hash_value !== want) begin
                        $error("hash_value mismatch: expected %h, actual %h",
                               want, m_hash_value);
                        fail_count++;
                    end
                end
            end

            // Seed takes effect for messages started after the write
            if (cfg_we)
                seed_q = cfg_wdata;
        end
        hashes_pending = expected_hashes.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_TICKS = 40;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data_word;
    logic [2:0]  s_byte_count;
    logic        s_is_first;
    logic        s_is_last;
    logic [31:0] s_message_length;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_hash_value;

    int fail_count;
    int hashes_pending;
    bit s_burst;
    bit m_burst;

    murmur2_hash_endian_neutral_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_byte_count     (s_byte_count),
        .s_is_first       (s_is_first),
        .s_is_last        (s_is_last),
        .s_message_length (s_message_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hash_value     (m_hash_value)
    );

    hash_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_byte_count     (s_byte_count),
        .s_is_first       (s_is_first),
        .s_is_last        (s_is_last),
        .s_message_length (s_message_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hash_value     (m_hash_value),
        .fail_count       (fail_count),
        .hashes_pending   (hashes_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Present one word after a random gap and hold it until the transfer
    task automatic send_word(input logic [31:0] word, input logic [2:0] count,
                             input logic first, input logic last,
                             input logic [31:0] length);
        int gap;
        gap = s_burst ? 0 : $urandom_range(0, 16);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_word      <= word;
        s_byte_count     <= count;
        s_is_first       <= first;
        s_is_last        <= last;
        s_message_length <= length;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every hash is back and the core is quiet
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (hashes_pending != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    task automatic load_seed(input logic [31:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed messages, with stray and unterminated words mixed in
    task automatic run_traffic(input int target);
        int sent;
        int kind;
        int nbytes;
        int nfull;
        int n;
        int last_cnt;
        logic [31:0] declared;
        logic [2:0]  cnt;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 7) == 0) begin
                s_burst = ($urandom_range(0, 2) == 0);
                m_burst = ($urandom_range(0, 2) == 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120)
                                                     : $urandom_range(0, 24);
                nfull    = nbytes / 4;
                declared = ($urandom_range(0, 7) == 0) ? $urandom : 32'(nbytes);
                if (nbytes % 4 != 0) begin
                    n        = nfull + 1;
                    last_cnt = nbytes % 4;
                end else if (nfull > 0 && $urandom_range(0, 1) == 1) begin
                    n        = nfull;
                    last_cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 7) : 4;
                end else begin
                    n        = nfull + 1;
                    last_cnt = 0;
                end
                for (int i = 0; i < n; i++) begin
                    if (i == n - 1)
                        cnt = 3'(last_cnt);
                    else
                        cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
                    send_word($urandom, cnt, i == 0, i == n - 1,
                              (i == 0) ? declared : $urandom);
                end
                sent += n;
            end else if (kind < 93) begin
                send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom);
                sent++;
            end else begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    send_word($urandom, 3'($urandom_range(0, 7)),
                              (i == 0) && ($urandom_range(0, 1) == 1), 1'b0, $urandom);
                sent += n;
            end
        end
    endtask

    // Accept hashes after a random stall per transfer
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = m_burst ? 0 : $urandom_range(0, 16);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // End the run if neither channel moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("murmur2_hash_endian_neutral_core test failed");
        $finish;
    end

    initial begin : stimulus
        aresetn          = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_data_word      = '0;
        s_byte_count     = '0;
        s_is_first       = 1'b0;
        s_is_last        = 1'b0;
        s_message_length = '0;
        s_burst          = 1'b0;
        m_burst          = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Single-word messages over every byte count, seed at reset value
        send_word(32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0000_0000);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FF80, 3'd1, 1'b1, 1'b1, 32'd1);
        send_word(32'h1234_5678, 3'd2, 1'b1, 1'b1, 32'd2);
        send_word(32'hA5A5_A5A5, 3'd3, 1'b1, 1'b1, 32'd3);
        send_word(32'h0000_0000, 3'd5, 1'b1, 1'b1, 32'd4);
        send_word(32'hDEAD_BEEF, 3'd6, 1'b1, 1'b1, 32'd4);
        send_word(32'h0000_0001, 3'd7, 1'b1, 1'b1, 32'h8000_0000);
        // Odd counts on non-last words are ignored
        send_word(32'h0302_0100, 3'd0, 1'b1, 1'b0, 32'd9);
        send_word(32'h0706_0504, 3'd7, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FF08, 3'd1, 1'b0, 1'b1, 32'h0000_0000);
        // Continue from the previous message without a first word
        send_word(32'h55AA_55AA, 3'd3, 1'b0, 1'b1, 32'h0000_0000);
        send_word(32'h1111_1111, 3'd4, 1'b0, 1'b0, 32'h0000_0000);
        send_word(32'h2222_2222, 3'd0, 1'b0, 1'b1, 32'h0000_0000);
        // Restart in the middle of a message
        send_word(32'h3333_3333, 3'd4, 1'b1, 1'b0, 32'd12);
        send_word(32'h4444_4444, 3'd4, 1'b1, 1'b0, 32'd8);
        send_word(32'h5555_5555, 3'd2, 1'b0, 1'b1, 32'd0);

        load_seed(32'hFFFF_FFFF);
        run_traffic(205);
        load_seed(32'h0000_0000);
        run_traffic(205);
        load_seed(32'h8000_0000);
        run_traffic(205);
        repeat (3) begin
            load_seed($urandom);
            run_traffic(205);
        end

        drain();
        if (fail_count == 0 && hashes_pending == 0)
            $display("murmur2_hash_endian_neutral_core test passed");
        else
            $display("murmur2_hash_endian_neutral_core test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mmh_pkg.sv
design/mmh_front.sv
design/mmh_queue.sv
design/mmh_back.sv
design/murmur2_hash_endian_neutral_core.sv
test/hash_checker.sv
test/tb_top.sv
